[sv/rgb2hsl_pkg.sv]
package rgb2hsl_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int HUE_FRAC_BITS = 6;
  localparam int FIELD_BITS = 16;
  localparam int HUE_BITS = 15;

  localparam int SECTOR = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN = 360 << HUE_FRAC_BITS;
  localparam int SECTOR_BITS = $clog2(SECTOR + 1);
  localparam int HUE_CALC_BITS = $clog2(FULL_TURN + 1);
  localparam int DIV_QUO_BITS = (CHANNEL_BITS > SECTOR_BITS) ? CHANNEL_BITS : SECTOR_BITS;
  localparam int DIV_NUM_BITS = CHANNEL_BITS + DIV_QUO_BITS;

  typedef logic [1:0] sector_t;
  localparam sector_t SEC_RED = 2'd0;
  localparam sector_t SEC_GREEN = 2'd1;
  localparam sector_t SEC_BLUE = 2'd2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] red;
    logic [FIELD_BITS-1:0] green;
    logic [FIELD_BITS-1:0] blue;
    logic [FIELD_BITS-1:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]   hue;
    logic [FIELD_BITS-1:0] saturation;
    logic [FIELD_BITS-1:0] lightness;
    logic [FIELD_BITS-1:0] alpha_out;
  } out_item_t;

endpackage

[sv/rgb2hsl_div.sv]
module rgb2hsl_div #(
  parameter int DW = 16,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic [DW-1:0] den_nxt [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] src_rem;
    logic [QW-1:0] src_low;
    logic [QW-1:0] src_quo;
    logic [DW-1:0] src_den;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    if (k == 0) begin : g_first
      assign src_rem = num[DW+QW-1:QW];
      assign src_low = num[QW-1:0];
      assign src_quo = '0;
      assign src_den = den;
    end else begin : g_next
      assign src_rem = rem_r[k-1];
      assign src_low = low_r[k-1];
      assign src_quo = quo_r[k-1];
      assign src_den = den_r[k-1];
    end

    always_comb begin
      trial = {src_rem, src_low[QW-1]};
      diff = {1'b0, trial} - {2'b00, src_den};
      low_nxt[k] = {src_low[QW-2:0], 1'b0};
      den_nxt[k] = src_den;
      if (!diff[DW+1]) begin
        rem_nxt[k] = diff[DW-1:0];
        quo_nxt[k] = {src_quo[QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DW-1:0];
        quo_nxt[k] = {src_quo[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= low_nxt[k];
      quo_r[k] <= quo_nxt[k];
      den_r[k] <= den_nxt[k];
    end
  end

  assign quo = quo_r[QW-1];

endmodule

[sv/rgb_to_hsl_converter.sv]
// Channel  Ports                      Handshake
// input    start, busy, in_item       taken when start is high and busy is low
// result   out_valid, out_item        strobed for one cycle, always taken
//
// One item enters every cycle; busy stays low.
// The two restoring dividers resolve one quotient bit per pipeline stage; each item
// passes the stage A and B registers, the divider stages and the output register.
// Synchronous reset clears only the valid bits; no clearing pass is needed.
// Items in flight always advance, since the receiver cannot stall.
module rgb_to_hsl_converter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  rgb2hsl_pkg::in_item_t  in_item,
  output logic                   out_valid,
  output rgb2hsl_pkg::out_item_t out_item
);

  import rgb2hsl_pkg::*;

  localparam int CH = CHANNEL_BITS;
  localparam int DQ = DIV_QUO_BITS;
  localparam logic [CH-1:0] CH_ONE = '1;
  localparam logic [CH:0] TWO_ONE = {CH_ONE, 1'b0};

  logic          a_vld_r, a_vld_nxt;
  logic [CH-1:0] a_mx_r, a_mx_nxt;
  logic [CH-1:0] a_mn_r, a_mn_nxt;
  logic [CH-1:0] a_mag_r, a_mag_nxt;
  logic          a_neg_r, a_neg_nxt;
  sector_t       a_sec_r, a_sec_nxt;
  logic [FIELD_BITS-1:0] a_alpha_r;

  logic [CH-1:0] r, g, b;
  logic          r_max, g_max;

  always_comb begin
    r = in_item.red[CH-1:0];
    g = in_item.green[CH-1:0];
    b = in_item.blue[CH-1:0];
    a_vld_nxt = start && !busy;
    r_max = (r >= g) && (r >= b);
    g_max = !r_max && (g >= b);
    a_mn_nxt = r;
    if (g < a_mn_nxt) begin
      a_mn_nxt = g;
    end
    if (b < a_mn_nxt) begin
      a_mn_nxt = b;
    end
    if (r_max) begin
      a_sec_nxt = SEC_RED;
      a_mx_nxt = r;
      a_neg_nxt = g < b;
      a_mag_nxt = a_neg_nxt ? (b - g) : (g - b);
    end else if (g_max) begin
      a_sec_nxt = SEC_GREEN;
      a_mx_nxt = g;
      a_neg_nxt = b < r;
      a_mag_nxt = a_neg_nxt ? (r - b) : (b - r);
    end else begin
      a_sec_nxt = SEC_BLUE;
      a_mx_nxt = b;
      a_neg_nxt = r < g;
      a_mag_nxt = a_neg_nxt ? (g - r) : (r - g);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_mx_r <= a_mx_nxt;
    a_mn_r <= a_mn_nxt;
    a_mag_r <= a_mag_nxt;
    a_neg_r <= a_neg_nxt;
    a_sec_r <= a_sec_nxt;
    a_alpha_r <= in_item.alpha_in;
  end

  logic                    b_vld_r;
  logic                    b_grey_r, b_grey_nxt;
  logic                    b_neg_r;
  sector_t                 b_sec_r;
  logic [CH-1:0]           b_light_r, b_light_nxt;
  logic [CH-1:0]           b_den_r, b_den_nxt;
  logic [CH-1:0]           b_spread_r, b_spread_nxt;
  logic [DIV_NUM_BITS-1:0] b_num_s_r, b_num_s_nxt;
  logic [DIV_NUM_BITS-1:0] b_num_h_r, b_num_h_nxt;
  logic [FIELD_BITS-1:0]   b_alpha_r;
  logic [CH:0]             sum;
  logic [CH:0]             den_wide;

  always_comb begin
    sum = {1'b0, a_mx_r} + {1'b0, a_mn_r};
    b_light_nxt = sum[CH:1];
    b_spread_nxt = a_mx_r - a_mn_r;
    b_grey_nxt = a_mx_r == a_mn_r;
    den_wide = (sum > {1'b0, CH_ONE}) ? (TWO_ONE - sum) : sum;
    b_den_nxt = den_wide[CH-1:0];
    b_num_s_nxt = DIV_NUM_BITS'({b_spread_nxt, {CH{1'b0}}}) - DIV_NUM_BITS'(b_spread_nxt);
    b_num_h_nxt = DIV_NUM_BITS'(a_mag_r) * DIV_NUM_BITS'(SECTOR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_grey_r <= b_grey_nxt;
    b_neg_r <= a_neg_r;
    b_sec_r <= a_sec_r;
    b_light_r <= b_light_nxt;
    b_den_r <= b_den_nxt;
    b_spread_r <= b_spread_nxt;
    b_num_s_r <= b_num_s_nxt;
    b_num_h_r <= b_num_h_nxt;
    b_alpha_r <= a_alpha_r;
  end

  logic [DQ-1:0] quo_s;
  logic [DQ-1:0] quo_h;

  rgb2hsl_div #(
    .DW(CH),
    .QW(DQ)
  ) u_div_sat (
    .clk(clk),
    .num(b_num_s_r),
    .den(b_den_r),
    .quo(quo_s)
  );

  rgb2hsl_div #(
    .DW(CH),
    .QW(DQ)
  ) u_div_hue (
    .clk(clk),
    .num(b_num_h_r),
    .den(b_spread_r),
    .quo(quo_h)
  );

  logic                  sb_vld_r [DQ];
  logic                  sb_grey_r [DQ];
  logic                  sb_neg_r [DQ];
  sector_t               sb_sec_r [DQ];
  logic [CH-1:0]         sb_light_r [DQ];
  logic [FIELD_BITS-1:0] sb_alpha_r [DQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DQ; k++) begin
        sb_vld_r[k] <= 1'b0;
      end
    end else begin
      sb_vld_r[0] <= b_vld_r;
      for (int k = 1; k < DQ; k++) begin
        sb_vld_r[k] <= sb_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sb_grey_r[0] <= b_grey_r;
    sb_neg_r[0] <= b_neg_r;
    sb_sec_r[0] <= b_sec_r;
    sb_light_r[0] <= b_light_r;
    sb_alpha_r[0] <= b_alpha_r;
    for (int k = 1; k < DQ; k++) begin
      sb_grey_r[k] <= sb_grey_r[k-1];
      sb_neg_r[k] <= sb_neg_r[k-1];
      sb_sec_r[k] <= sb_sec_r[k-1];
      sb_light_r[k] <= sb_light_r[k-1];
      sb_alpha_r[k] <= sb_alpha_r[k-1];
    end
  end

  logic                     out_vld_r;
  out_item_t                out_item_r, out_item_nxt;
  logic [HUE_CALC_BITS-1:0] q_hue;
  logic [HUE_CALC_BITS-1:0] hue_base;
  logic [HUE_CALC_BITS-1:0] hue_calc;

  always_comb begin
    q_hue = HUE_CALC_BITS'(quo_h[SECTOR_BITS-1:0]);
    unique case (sb_sec_r[DQ-1])
      SEC_RED: begin
        hue_base = sb_neg_r[DQ-1] ? HUE_CALC_BITS'(6 * SECTOR) : '0;
      end
      SEC_GREEN: begin
        hue_base = HUE_CALC_BITS'(2 * SECTOR);
      end
      SEC_BLUE: begin
        hue_base = HUE_CALC_BITS'(4 * SECTOR);
      end
      default: begin
        hue_base = '0;
      end
    endcase
    hue_calc = sb_neg_r[DQ-1] ? (hue_base - q_hue) : (hue_base + q_hue);
    if (hue_calc >= HUE_CALC_BITS'(FULL_TURN)) begin
      hue_calc = HUE_CALC_BITS'(FULL_TURN - 1);
    end
    out_item_nxt.lightness = FIELD_BITS'(sb_light_r[DQ-1]);
    out_item_nxt.alpha_out = sb_alpha_r[DQ-1];
    if (sb_grey_r[DQ-1]) begin
      out_item_nxt.hue = '0;
      out_item_nxt.saturation = '0;
    end else begin
      out_item_nxt.hue = hue_calc[HUE_BITS-1:0];
      out_item_nxt.saturation = FIELD_BITS'(quo_s[CH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= sb_vld_r[DQ-1];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy = 1'b0;
  assign out_valid = out_vld_r;
  assign out_item = out_item_r;

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.hue < HUE_BITS'(FULL_TURN)))
    else $error("Hue of a result item reaches a full turn.");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.saturation == '0)) |-> (out_item.hue == '0))
    else $error("An item without saturation carries a nonzero hue.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("A result strobe follows a reset cycle.");
`endif

endmodule
